FILE: design/stack_pattern_removal_core_assert.svh
// Assertion macros for the stack pattern removal core checker.
// Needs nothing but the simulator's assertion support.
`ifndef STACK_PATTERN_REMOVAL_CORE_ASSERT_SVH
`define STACK_PATTERN_REMOVAL_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define SPRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define SPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/sprc_pkg.sv
// Shared constants, codes and types of the stack pattern removal core.
// Used by every module of the block but the stack RAM; depends on nothing.
`default_nettype none

package sprc_pkg;

	localparam int STACK_DEPTH  = 4096;
	localparam int MAX_PATTERN  = 32;

	localparam int ADDR_W       = $clog2(STACK_DEPTH);
	localparam int DEPTH_W      = $clog2(STACK_DEPTH + 1);
	localparam int CHAR_W       = 8;
	localparam int ACTION_W     = 2;
	localparam int READ_INDEX_W = 12;
	localparam int LEN_W        = 6;
	localparam int KW           = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	localparam int CFG_DATA_W   = 64;
	localparam int NUM_PAT_REGS = (MAX_PATTERN + 7) / 8;
	localparam int PATTERN_W    = NUM_PAT_REGS * CFG_DATA_W;
	localparam int CFG_IDX_W    = $clog2(NUM_PAT_REGS + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(0);
	localparam int                   CFG_PATTERN_BASE   = 1;
	localparam logic [LEN_W-1:0]     PATTERN_LENGTH_RST = LEN_W'(1);

	localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_CMP_LAST,
		S_READ,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0]     len;
		logic [PATTERN_W-1:0] pattern;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               exploded;
		logic               overflow;
		logic [CHAR_W-1:0]  read_char;
		logic               read_valid;
	} result_t;

endpackage

`default_nettype wire

FILE: design/sprc_stack_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the stack.
// Registered read data; no dependencies.
`default_nettype none

module sprc_stack_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/sprc_cfg_regs.sv
// Configuration registers: pattern length and packed pattern characters.
// Depends on sprc_pkg.
`default_nettype none

module sprc_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [sprc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sprc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
	output sprc_pkg::cfg_t                          cfg
);

	logic [sprc_pkg::LEN_W-1:0]      len_q;
	logic [sprc_pkg::CFG_DATA_W-1:0] pat_q [sprc_pkg::NUM_PAT_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= sprc_pkg::PATTERN_LENGTH_RST;
			for (int i = 0; i < sprc_pkg::NUM_PAT_REGS; i++) begin
				pat_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == sprc_pkg::CFG_PATTERN_LENGTH) begin
				len_q <= cfg_wr_data[sprc_pkg::LEN_W-1:0];
			end
			for (int i = 0; i < sprc_pkg::NUM_PAT_REGS; i++) begin
				if (cfg_index == sprc_pkg::CFG_IDX_W'(sprc_pkg::CFG_PATTERN_BASE + i)) begin
					pat_q[i] <= cfg_wr_data;
				end
			end
		end
	end

	always_comb begin
		// saturate the length at the pattern capacity
		if (len_q > sprc_pkg::LEN_W'(sprc_pkg::MAX_PATTERN)) begin
			cfg.len = sprc_pkg::LEN_W'(sprc_pkg::MAX_PATTERN);
		end else begin
			cfg.len = len_q;
		end
		for (int i = 0; i < sprc_pkg::NUM_PAT_REGS; i++) begin
			cfg.pattern[i*sprc_pkg::CFG_DATA_W +: sprc_pkg::CFG_DATA_W] = pat_q[i];
		end
	end

endmodule

`default_nettype wire

FILE: design/sprc_ctrl.sv
// Sequencer: push/read/clear handling, top-of-stack compare loop,
// depth register and output register. Depends on sprc_pkg.
`default_nettype none

module sprc_ctrl (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [sprc_pkg::ACTION_W-1:0]        action,
	input  wire logic [sprc_pkg::CHAR_W-1:0]          char_in,
	input  wire logic [sprc_pkg::READ_INDEX_W-1:0]    read_index,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output sprc_pkg::result_t                         result,
	input  wire sprc_pkg::cfg_t                       cfg,
	output sprc_pkg::mem_req_t                        mem_req,
	input  wire logic [sprc_pkg::CHAR_W-1:0]          rdata
);

	sprc_pkg::state_t  state_q, state_d;
	sprc_pkg::result_t res_q, out_q, idle_res;

	logic [sprc_pkg::DEPTH_W-1:0] depth_q, base_q, d1;
	logic [sprc_pkg::LEN_W-1:0]   len_q, k_q;
	logic [sprc_pkg::KW-1:0]      k_s1;
	logic                         cmp_s1, match_q, rd_ok_q, out_valid_q;
	logic                         accept, out_load, full, need_cmp, char_eq;
	logic                         is_push, is_read;

	assign accept   = in_valid && (state_q == sprc_pkg::S_IDLE);
	assign is_push  = (action == sprc_pkg::ACT_PUSH);
	assign is_read  = (action == sprc_pkg::ACT_READ);
	assign full     = (depth_q == sprc_pkg::DEPTH_W'(sprc_pkg::STACK_DEPTH));
	assign d1       = depth_q + sprc_pkg::DEPTH_W'(1);
	assign need_cmp = (cfg.len != '0) && (d1 >= sprc_pkg::DEPTH_W'(cfg.len));
	assign char_eq  = (rdata == cfg.pattern[{k_s1, 3'b000} +: sprc_pkg::CHAR_W]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sprc_pkg::S_IDLE: begin
				if (accept) begin
					unique case (action)
						sprc_pkg::ACT_PUSH: begin
							state_d = (!full && need_cmp) ? sprc_pkg::S_CMP : sprc_pkg::S_DONE;
						end
						sprc_pkg::ACT_READ: state_d = sprc_pkg::S_READ;
						default:            state_d = sprc_pkg::S_DONE;
					endcase
				end
			end
			sprc_pkg::S_CMP: begin
				if (k_q == len_q - sprc_pkg::LEN_W'(1)) begin
					state_d = sprc_pkg::S_CMP_LAST;
				end
			end
			sprc_pkg::S_CMP_LAST: state_d = sprc_pkg::S_DONE;
			sprc_pkg::S_READ:     state_d = sprc_pkg::S_DONE;
			sprc_pkg::S_DONE: begin
				if (out_load) begin
					state_d = sprc_pkg::S_IDLE;
				end
			end
			default: state_d = sprc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != sprc_pkg::S_IDLE);
		out_load      = (state_q == sprc_pkg::S_DONE) && (!out_valid_q || !out_stall);
		mem_req.we    = accept && is_push && !full;
		mem_req.waddr = sprc_pkg::ADDR_W'(depth_q);
		mem_req.wdata = char_in;
		mem_req.re    = (accept && is_read) || (state_q == sprc_pkg::S_CMP);
		if (state_q == sprc_pkg::S_CMP) begin
			mem_req.raddr = sprc_pkg::ADDR_W'(base_q + sprc_pkg::DEPTH_W'(k_q));
		end else begin
			mem_req.raddr = sprc_pkg::ADDR_W'(read_index);
		end
	end

	always_comb begin
		idle_res       = '0;
		idle_res.depth = depth_q;
		case (action)
			sprc_pkg::ACT_PUSH: begin
				if (full) begin
					idle_res.overflow = 1'b1;
				end else begin
					idle_res.depth = d1;
				end
			end
			sprc_pkg::ACT_CLEAR: idle_res.depth = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sprc_pkg::S_IDLE;
			depth_q     <= '0;
			cmp_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_s1  <= (state_q == sprc_pkg::S_CMP);
			if (state_q == sprc_pkg::S_DONE) begin
				depth_q <= res_q.depth;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q  <= d1 - sprc_pkg::DEPTH_W'(cfg.len);
			len_q   <= cfg.len;
			k_q     <= '0;
			match_q <= 1'b1;
			rd_ok_q <= (sprc_pkg::DEPTH_W'(read_index) < depth_q);
			res_q   <= idle_res;
		end
		if (state_q == sprc_pkg::S_CMP) begin
			k_q  <= k_q + sprc_pkg::LEN_W'(1);
			k_s1 <= k_q[sprc_pkg::KW-1:0];
		end
		if (cmp_s1) begin
			match_q <= match_q & char_eq;
		end
		if ((state_q == sprc_pkg::S_CMP_LAST) && match_q && char_eq) begin
			res_q.depth    <= base_q;
			res_q.exploded <= 1'b1;
		end
		if (state_q == sprc_pkg::S_READ) begin
			res_q.read_valid <= rd_ok_q;
			res_q.read_char  <= rd_ok_q ? rdata : '0;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

`default_nettype wire

FILE: design/stack_pattern_removal_core.sv
// Stack pattern removal core: pushes characters onto a stack in RAM and
// pops the top entries whenever they spell the configured pattern.
// Channels: input transactions carry action, char_in and read_index under
//   in_valid/in_stall; each input transaction yields exactly one output
//   transaction (depth, exploded, overflow, read_char, read_valid) under
//   out_valid/out_stall. Configuration uses cfg_wr_en/cfg_index/cfg_wr_data
//   and must be written only while the block is idle.
// Item sequence: clear, unused codes, overflowing pushes and pushes that
//   need no compare go from idle straight to the done state; reads pass
//   through the read state; a push that checks the pattern runs the compare
//   loop, which reads one stack entry per cycle through the single RAM read
//   port, then the last compare state. A new item is accepted only in idle.
// Result output: the result appears on out_valid the cycle after the item
//   finishes; the next item is accepted in that same cycle.
// Receiver stall: a finished result holds in the output register while the
//   next item is accepted and processed; that item then waits before its
//   own result is loaded.
// Reset: depth goes to zero, pattern_length to 1, pattern characters to 0;
//   the stack RAM is not cleared and needs no clearing pass.
`default_nettype none

module stack_pattern_removal_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [sprc_pkg::ACTION_W-1:0]        action,
	input  wire logic [sprc_pkg::CHAR_W-1:0]          char_in,
	input  wire logic [sprc_pkg::READ_INDEX_W-1:0]    read_index,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic      [sprc_pkg::DEPTH_W-1:0]         depth,
	output logic                                      exploded,
	output logic                                      overflow,
	output logic      [sprc_pkg::CHAR_W-1:0]          read_char,
	output logic                                      read_valid,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [sprc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sprc_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

	sprc_pkg::cfg_t     cfg;
	sprc_pkg::mem_req_t mem_req;
	sprc_pkg::result_t  result;
	logic [sprc_pkg::CHAR_W-1:0] rdata;

	sprc_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	sprc_stack_ram #(
		.DATA_W (sprc_pkg::CHAR_W),
		.DEPTH  (sprc_pkg::STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	sprc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.char_in    (char_in),
		.read_index (read_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result),
		.cfg        (cfg),
		.mem_req    (mem_req),
		.rdata      (rdata)
	);

	assign depth      = result.depth;
	assign exploded   = result.exploded;
	assign overflow   = result.overflow;
	assign read_char  = result.read_char;
	assign read_valid = result.read_valid;

endmodule

`default_nettype wire

FILE: design/sprc_checker.sv
// Port-level checker for the stack pattern removal core, bound to the top.
// Depends on sprc_pkg and stack_pattern_removal_core_assert.svh.
`default_nettype none

`include "stack_pattern_removal_core_assert.svh"

module sprc_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [sprc_pkg::DEPTH_W-1:0]       depth,
	input wire logic                               exploded,
	input wire logic                               overflow,
	input wire logic                               read_valid
);

	`SPRC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(depth), "output transaction dropped or changed under stall")

	`SPRC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "input accepted while previous transaction in progress")

	`SPRC_ASSERT_SAME(a_overflow_full, clk, arst_n, out_valid && overflow, depth == sprc_pkg::DEPTH_W'(sprc_pkg::STACK_DEPTH) && !exploded, "overflow reported on a stack that is not full")

	`SPRC_ASSERT_SAME(a_read_excl, clk, arst_n, out_valid && read_valid, !exploded && !overflow, "read result flagged as push outcome")

endmodule

bind stack_pattern_removal_core sprc_checker u_sprc_checker (.*);

`default_nettype wire

FILE: verif/tb_stack_pattern_removal_core.sv
// Self-checking testbench for stack_pattern_removal_core: a queue-fed driver and a
// clocked monitor check every output transaction against a shadow stack model.
// Depends on sprc_pkg and the core RTL only.
`default_nettype none

module tb_stack_pattern_removal_core;

	localparam int SETTLE = 40;
	localparam int IDLE_PCT = 7;
	localparam logic [sprc_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [sprc_pkg::ACTION_W-1:0]     act;
		logic [sprc_pkg::CHAR_W-1:0]       ch;
		logic [sprc_pkg::READ_INDEX_W-1:0] idx;
	} stack_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [sprc_pkg::ACTION_W-1:0] action = sprc_pkg::ACT_CLEAR;
	logic [sprc_pkg::CHAR_W-1:0] char_in = '0;
	logic [sprc_pkg::READ_INDEX_W-1:0] read_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [sprc_pkg::DEPTH_W-1:0] depth;
	logic exploded;
	logic overflow;
	logic [sprc_pkg::CHAR_W-1:0] read_char;
	logic read_valid;
	logic cfg_wr_en = 1'b0;
	logic [sprc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sprc_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

	stack_op_t pending_ops[$];
	sprc_pkg::result_t expected_results[$];
	stack_op_t next_op;
	sprc_pkg::result_t oldest;

	logic [sprc_pkg::CHAR_W-1:0] shadow_stack [sprc_pkg::STACK_DEPTH];
	int shadow_depth = 0;
	logic [sprc_pkg::LEN_W-1:0] pat_len = sprc_pkg::PATTERN_LENGTH_RST;
	logic [sprc_pkg::CFG_DATA_W-1:0] pat_regs [sprc_pkg::NUM_PAT_REGS];

	bit steady = 1'b0;
	int errors = 0;
	int ops_accepted = 0;
	int results_checked = 0;
	int removals_seen = 0;
	int overflows_seen = 0;
	int reads_seen = 0;
	int phase_lens [7];

	stack_pattern_removal_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.char_in(char_in),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.depth(depth),
		.exploded(exploded),
		.overflow(overflow),
		.read_char(read_char),
		.read_valid(read_valid),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int active_len();
		return (int'(pat_len) > sprc_pkg::MAX_PATTERN) ? sprc_pkg::MAX_PATTERN : int'(pat_len);
	endfunction

	function automatic logic [sprc_pkg::CHAR_W-1:0] pattern_byte(int k);
		return pat_regs[(k >> 3) & 3][8 * (k & 7) +: 8];
	endfunction

	function automatic sprc_pkg::result_t apply_to_stack(stack_op_t op);
		sprc_pkg::result_t r;
		int len;
		int base;
		int k;
		bit hit;
		r = '0;
		case (op.act)
			sprc_pkg::ACT_PUSH: begin
				if (shadow_depth >= sprc_pkg::STACK_DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					len = active_len();
					shadow_stack[shadow_depth] = op.ch;
					shadow_depth++;
					if (len != 0 && shadow_depth >= len) begin
						base = shadow_depth - len;
						hit = 1'b1;
						for (k = 0; k < len; k++)
							if (shadow_stack[base + k] != pattern_byte(k))
								hit = 1'b0;
						if (hit) begin
							shadow_depth = base;
							r.exploded = 1'b1;
						end
					end
				end
			end
			sprc_pkg::ACT_READ: begin
				if (int'(op.idx) < shadow_depth) begin
					r.read_valid = 1'b1;
					r.read_char = shadow_stack[op.idx];
				end
			end
			sprc_pkg::ACT_CLEAR: begin
				shadow_depth = 0;
			end
			default: ;
		endcase
		r.depth = sprc_pkg::DEPTH_W'(shadow_depth);
		return r;
	endfunction

	task automatic flag_mismatch(string field, int got, int want);
		errors++;
		$display("mismatch on result %0d: %s got %0d want %0d", results_checked, field, got, want);
	endtask

	task automatic add_op(logic [sprc_pkg::ACTION_W-1:0] act, logic [sprc_pkg::CHAR_W-1:0] ch,
			logic [sprc_pkg::READ_INDEX_W-1:0] idx);
		pending_ops.push_back('{act: act, ch: ch, idx: idx});
	endtask

	task automatic write_reg(logic [sprc_pkg::CFG_IDX_W-1:0] idx,
			logic [sprc_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == sprc_pkg::CFG_PATTERN_LENGTH)
			pat_len = val[sprc_pkg::LEN_W-1:0];
		else
			pat_regs[int'(idx) - sprc_pkg::CFG_PATTERN_BASE] = val;
	endtask

	task automatic load_pattern(int len, bit narrow);
		logic [sprc_pkg::CFG_DATA_W-1:0] v;
		int r;
		int b;
		for (r = 0; r < sprc_pkg::NUM_PAT_REGS; r++) begin
			v = {$urandom, $urandom};
			if (narrow)
				for (b = 0; b < 8; b++)
					v[8 * b +: 8] = 8'h61 + 8'($urandom_range(0, 2));
			write_reg(sprc_pkg::CFG_IDX_W'(sprc_pkg::CFG_PATTERN_BASE + r), v);
		end
		write_reg(sprc_pkg::CFG_PATTERN_LENGTH, sprc_pkg::CFG_DATA_W'(len));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic queue_drain();
		int i;
		for (i = 0; i < shadow_depth; i++)
			add_op(sprc_pkg::ACT_READ, 8'($urandom), sprc_pkg::READ_INDEX_W'(i));
		if (shadow_depth < sprc_pkg::STACK_DEPTH)
			add_op(sprc_pkg::ACT_READ, 8'($urandom), sprc_pkg::READ_INDEX_W'(shadow_depth));
		add_op(sprc_pkg::ACT_READ, 8'($urandom), '1);
	endtask

	task automatic queue_phase(int n);
		int count;
		int len;
		int k;
		int cut;
		int r;
		int j;
		logic [sprc_pkg::READ_INDEX_W-1:0] ridx;
		len = active_len();
		count = 0;
		while (count < n) begin
			r = $urandom_range(0, 99);
			if (len != 0 && r < 35) begin
				for (k = 0; k < len; k++)
					add_op(sprc_pkg::ACT_PUSH, pattern_byte(k), 12'($urandom));
				count += len;
			end else if (len > 1 && r < 55) begin
				cut = $urandom_range(1, len - 1);
				for (k = 0; k < cut; k++)
					add_op(sprc_pkg::ACT_PUSH, pattern_byte(k), 12'($urandom));
				for (k = 0; k < len; k++)
					add_op(sprc_pkg::ACT_PUSH, pattern_byte(k), 12'($urandom));
				for (k = cut; k < len; k++)
					add_op(sprc_pkg::ACT_PUSH, pattern_byte(k), 12'($urandom));
				count += 2 * len;
			end else if (len != 0 && r < 63) begin
				j = $urandom_range(0, len - 1);
				for (k = 0; k < len; k++)
					add_op(sprc_pkg::ACT_PUSH,
						(k == j) ? pattern_byte(k) ^ 8'($urandom_range(1, 255))
						: pattern_byte(k), 12'($urandom));
				count += len;
			end else if (r < 74) begin
				add_op(sprc_pkg::ACT_PUSH,
					pattern_byte($urandom_range(0, sprc_pkg::MAX_PATTERN - 1)),
					12'($urandom));
				count++;
			end else if (r < 84) begin
				add_op(sprc_pkg::ACT_PUSH, 8'($urandom), 12'($urandom));
				count++;
			end else if (r < 94) begin
				ridx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 48));
				add_op(sprc_pkg::ACT_READ, 8'($urandom), ridx);
				count++;
			end else if (r < 97) begin
				add_op(sprc_pkg::ACT_CLEAR, 8'($urandom), 12'($urandom));
				count++;
			end else begin
				add_op(ACT_UNUSED, 8'($urandom), 12'($urandom));
				count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_to_stack('{act: action, ch: char_in,
					idx: read_index}));
				ops_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					action <= next_op.act;
					char_in <= next_op.ch;
					read_index <= next_op.idx;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("unexpected transaction, depth", int'(depth), -1);
				end else begin
					oldest = expected_results.pop_front();
					if (depth !== oldest.depth)
						flag_mismatch("depth", int'(depth), int'(oldest.depth));
					if (exploded !== oldest.exploded)
						flag_mismatch("exploded", int'(exploded), int'(oldest.exploded));
					if (overflow !== oldest.overflow)
						flag_mismatch("overflow", int'(overflow), int'(oldest.overflow));
					if (read_char !== oldest.read_char)
						flag_mismatch("read_char", int'(read_char), int'(oldest.read_char));
					if (read_valid !== oldest.read_valid)
						flag_mismatch("read_valid", int'(read_valid), int'(oldest.read_valid));
				end
				results_checked++;
				removals_seen += int'(exploded === 1'b1);
				overflows_seen += int'(overflow === 1'b1);
				reads_seen += int'(read_valid === 1'b1);
			end
			out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	initial begin
		#4000000;
		$display("stack_pattern_removal_core regression: fail");
		$finish;
	end

	initial begin
		int i;
		int p;
		for (i = 0; i < sprc_pkg::NUM_PAT_REGS; i++)
			pat_regs[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		add_op(sprc_pkg::ACT_PUSH, 8'h00, '0);
		add_op(sprc_pkg::ACT_PUSH, 8'hFF, '1);
		add_op(sprc_pkg::ACT_PUSH, 8'h41, '0);
		add_op(sprc_pkg::ACT_READ, 8'h00, 12'd0);
		add_op(sprc_pkg::ACT_READ, 8'hFF, 12'd1);
		add_op(sprc_pkg::ACT_READ, 8'h00, 12'd2);
		add_op(sprc_pkg::ACT_READ, 8'h00, '1);
		add_op(ACT_UNUSED, 8'hFF, '1);
		add_op(sprc_pkg::ACT_CLEAR, 8'h00, '0);
		add_op(sprc_pkg::ACT_READ, 8'h00, 12'd0);
		wait_idle();

		write_reg(sprc_pkg::CFG_PATTERN_LENGTH, '0);
		for (i = 0; i < 40; i++)
			add_op(sprc_pkg::ACT_PUSH, 8'($urandom), 12'($urandom));
		add_op(sprc_pkg::ACT_READ, 8'h00, '1);
		add_op(sprc_pkg::ACT_READ, 8'h00, 12'd0);
		add_op(sprc_pkg::ACT_READ, 8'h00, 12'd39);
		add_op(sprc_pkg::ACT_READ, 8'h00, 12'd2048);
		add_op(ACT_UNUSED, 8'h00, '0);
		add_op(sprc_pkg::ACT_CLEAR, 8'h00, '0);
		add_op(sprc_pkg::ACT_READ, 8'h00, 12'd0);
		wait_idle();

		write_reg(sprc_pkg::CFG_IDX_W'(sprc_pkg::CFG_PATTERN_BASE), 64'h0000_0000_0000_6261);
		write_reg(sprc_pkg::CFG_PATTERN_LENGTH, 64'd2);
		add_op(sprc_pkg::ACT_PUSH, 8'h61, '0);
		add_op(sprc_pkg::ACT_PUSH, 8'h61, '0);
		add_op(sprc_pkg::ACT_PUSH, 8'h62, '0);
		add_op(sprc_pkg::ACT_PUSH, 8'h62, '0);
		add_op(sprc_pkg::ACT_READ, 8'h00, 12'd0);
		wait_idle();

		for (i = 0; i < sprc_pkg::NUM_PAT_REGS; i++)
			write_reg(sprc_pkg::CFG_IDX_W'(sprc_pkg::CFG_PATTERN_BASE + i), '1);
		write_reg(sprc_pkg::CFG_PATTERN_LENGTH, 64'd63);
		for (i = 0; i < sprc_pkg::MAX_PATTERN; i++)
			add_op(sprc_pkg::ACT_PUSH, 8'hFF, '0);
		add_op(sprc_pkg::ACT_PUSH, 8'hFE, '0);
		add_op(sprc_pkg::ACT_READ, 8'h00, 12'd0);
		add_op(sprc_pkg::ACT_CLEAR, 8'h00, '0);
		wait_idle();

		phase_lens = '{1, 2, 3, $urandom_range(4, 20), 5, 32, 47};
		for (p = 0; p < 7; p++) begin
			steady = (p == 3);
			load_pattern(phase_lens[p], p[0]);
			queue_phase(50);
			wait_idle();
			queue_drain();
			wait_idle();
		end
		steady = 1'b0;

		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (expected_results.size() != 0)
			flag_mismatch("results still outstanding", expected_results.size(), 0);
		$display("covered %0d input transactions and %0d results over 11 pattern settings",
			ops_accepted, results_checked);
		$display("saw %0d removals, %0d dropped pushes, %0d valid reads",
			removals_seen, overflows_seen, reads_seen);
		if (errors == 0)
			$display("stack_pattern_removal_core regression: pass");
		else
			$display("stack_pattern_removal_core regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
